// ===== rtl/periodic_query_scheduler_unit_macros.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef PERIODIC_QUERY_SCHEDULER_UNIT_MACROS_SVH
`define PERIODIC_QUERY_SCHEDULER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that cons holds in the same cycle as ante.
`define PQS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define PQS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define PQS_ASSERT_NOW(label, ante, cons, msg)
`define PQS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/pqs_pkg.sv =====
// Package: types, constants and codes of the periodic query scheduler.
`timescale 1ns / 1ps
`default_nettype none

package pqs_pkg;

    localparam int CAPACITY = 64;
    localparam int TIME_W   = 40;
    localparam int ID_W     = 16;
    localparam int PER_W    = 16;

    localparam logic OP_REGISTER = 1'b0;
    localparam logic OP_NEXT     = 1'b1;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef enum logic [1:0] {
        ST_REGISTERED = 2'd0,
        ST_FULL       = 2'd1,
        ST_EMITTED    = 2'd2,
        ST_EMPTY      = 2'd3
    } t_status;

    typedef struct packed {
        logic             operation;
        logic [ID_W-1:0]  query_id;
        logic [PER_W-1:0] period;
    } t_in_word;

    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   due_id;
        logic [TIME_W-1:0] due_time;
    } t_out_word;

    typedef struct packed {
        logic [TIME_W-1:0] due;
        logic [ID_W-1:0]   id;
        logic [PER_W-1:0]  iv;
    } t_entry;

    // What a cell shows its neighbors.
    typedef struct packed {
        logic   vld;
        logic   gt;     // cell sorts after the broadcast key (or is empty)
        t_entry ent;
    } t_link;

    // Broadcast to every cell.
    typedef struct packed {
        logic   we;
        logic   pop;
        t_entry key;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/pqs_cell.sv =====
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module pqs_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  pqs_pkg::t_cell_ctl     i_ctl,
    input  pqs_pkg::t_link         i_prev,
    input  pqs_pkg::t_link         i_next,
    output pqs_pkg::t_link         o_link
);

    logic            r_vld;
    pqs_pkg::t_entry r_ent;
    logic            n_vld;
    pqs_pkg::t_entry n_ent;
    logic            w_gt;
    logic            w_left;
    logic            w_right;

    // Strictly after the key: equal keys stay ahead of the newcomer.
    assign w_gt = !r_vld
               || (r_ent.due > i_ctl.key.due)
               || ((r_ent.due == i_ctl.key.due) && (r_ent.id > i_ctl.key.id));

    always_comb begin
        n_vld = r_vld;
        n_ent = r_ent;
        if (i_ctl.pop) begin
            // Slots ahead of the key move one slot toward the head, key drops into the gap.
            w_left  = w_gt;
            w_right = i_next.gt;
            if (w_left) begin
                n_vld = r_vld;
                n_ent = r_ent;
            end else if (w_right) begin
                n_vld = 1'b1;
                n_ent = i_ctl.key;
            end else begin
                n_vld = i_next.vld;
                n_ent = i_next.ent;
            end
        end else begin
            // Open a gap at the first later slot, shift the tail back.
            w_left  = i_prev.gt;
            w_right = w_gt;
            if (w_left) begin
                n_vld = i_prev.vld;
                n_ent = i_prev.ent;
            end else if (w_right) begin
                n_vld = 1'b1;
                n_ent = i_ctl.key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.we) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_ent <= n_ent;
        end
    end

    assign o_link.vld = r_vld;
    assign o_link.gt  = w_gt;
    assign o_link.ent = r_ent;

endmodule

`default_nettype wire

// ===== rtl/periodic_query_scheduler_unit.sv =====
// Top level: periodic query scheduler built as a sorted chain of cells.
//
//  channel  | direction | handshake             | word
//  ---------+-----------+-----------------------+----------------------------
//  item     | in        | start high, busy low  | i_item   (pqs_pkg::t_in_word)
//  result   | out       | o_strobe for 1 cycle  | o_result (pqs_pkg::t_out_word)
//
// All cells compare against the broadcast key and shift on the same edge as an
// item is accepted, and the result is shown in the cycle after acceptance.
// busy stays low, so a new item can follow in every cycle.
// Synchronous active-low reset empties the queue by clearing each cell's
// valid bit; entry contents are not reset.
// The receiver cannot stall: o_strobe marks each result for one cycle only.
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_query_scheduler_unit_macros.svh"

module periodic_query_scheduler_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  pqs_pkg::t_in_word  i_item,
    output logic               o_strobe,
    output pqs_pkg::t_out_word o_result
);

    pqs_pkg::t_link     w_link [pqs_pkg::CAPACITY];
    pqs_pkg::t_link     w_head_prev;
    pqs_pkg::t_link     w_tail_next;
    pqs_pkg::t_cell_ctl w_ctl;
    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    logic [pqs_pkg::TIME_W:0] w_sum;
    logic               r_strobe;
    pqs_pkg::t_out_word r_result;
    pqs_pkg::t_out_word n_result;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_empty  = !w_link[0].vld;
    assign w_full   = w_link[pqs_pkg::CAPACITY-1].vld;

    // Reinsert key: head due time advanced by its own period, saturating.
    assign w_sum = {1'b0, w_link[0].ent.due}
                 + {{(pqs_pkg::TIME_W + 1 - pqs_pkg::PER_W){1'b0}}, w_link[0].ent.iv};

    always_comb begin
        w_ctl.we  = 1'b0;
        w_ctl.pop = (i_item.operation == pqs_pkg::OP_NEXT);
        w_ctl.key = '0;
        n_result  = '0;
        if (i_item.operation == pqs_pkg::OP_NEXT) begin
            w_ctl.key.due = w_sum[pqs_pkg::TIME_W] ? pqs_pkg::TIME_MAX
                                                   : w_sum[pqs_pkg::TIME_W-1:0];
            w_ctl.key.id  = w_link[0].ent.id;
            w_ctl.key.iv  = w_link[0].ent.iv;
            if (w_empty) begin
                n_result.status = pqs_pkg::ST_EMPTY;
            end else begin
                w_ctl.we          = w_accept;
                n_result.status   = pqs_pkg::ST_EMITTED;
                n_result.due_id   = w_link[0].ent.id;
                n_result.due_time = w_link[0].ent.due;
            end
        end else begin
            w_ctl.key.due = {{(pqs_pkg::TIME_W - pqs_pkg::PER_W){1'b0}}, i_item.period};
            w_ctl.key.id  = i_item.query_id;
            w_ctl.key.iv  = i_item.period;
            if (w_full) begin
                n_result.status = pqs_pkg::ST_FULL;
            end else begin
                w_ctl.we        = w_accept;
                n_result.status = pqs_pkg::ST_REGISTERED;
            end
        end
    end

    // Chain ends: nothing ahead of the head, an empty slot past the tail.
    assign w_head_prev = '{vld: 1'b0, gt: 1'b0, ent: '0};
    assign w_tail_next = '{vld: 1'b0, gt: 1'b1, ent: '0};

    for (genvar g = 0; g < pqs_pkg::CAPACITY; g++) begin : g_cell
        pqs_pkg::t_link w_prev;
        pqs_pkg::t_link w_next;
        if (g == 0) begin : g_first
            assign w_prev = w_head_prev;
        end else begin : g_mid_prev
            assign w_prev = w_link[g-1];
        end
        if (g == pqs_pkg::CAPACITY - 1) begin : g_last
            assign w_next = w_tail_next;
        end else begin : g_mid_next
            assign w_next = w_link[g+1];
        end
        pqs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_link  (w_link[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `PQS_ASSERT_NEXT(a_one_result, w_accept, o_strobe, "accepted word gave no result")
    `PQS_ASSERT_NOW(a_no_extra, o_strobe, $past(w_accept), "result without accepted word")
    `PQS_ASSERT_NOW(a_fill_order, w_link[1].vld, w_link[0].vld, "queue has a hole at head")
    `PQS_ASSERT_NOW(a_emit_nonempty, o_strobe && (o_result.status == pqs_pkg::ST_EMITTED), $past(w_link[0].vld), "emitted from empty queue")
    `PQS_ASSERT_NOW(a_full_refused, o_strobe && (o_result.status == pqs_pkg::ST_FULL), $past(w_link[pqs_pkg::CAPACITY-1].vld), "refused while not full")

endmodule

`default_nettype wire
